// ===== rtl/whp_pkg.sv =====
// Shared types and constants of the WAV header parser.
package whp_pkg;

  localparam int unsigned MinHeader = 44;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6d66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [15:0] FmtTagPcm = 16'h0001;
  localparam logic [15:0] FmtTagMp3 = 16'h0055;

  typedef enum logic [4:0] {
    PH_RIFF  = 5'd0,
    PH_RSIZE = 5'd1,
    PH_WAVE  = 5'd2,
    PH_FMT   = 5'd3,
    PH_FLEN  = 5'd4,
    PH_FTAG  = 5'd5,
    PH_CHAN  = 5'd6,
    PH_RATE  = 5'd7,
    PH_BRATE = 5'd8,
    PH_ALIGN = 5'd9,
    PH_BITS  = 5'd10,
    PH_MSKIP = 5'd11,
    PH_CTAG  = 5'd12,
    PH_CSIZE = 5'd13,
    PH_CSKIP = 5'd14,
    PH_DSIZE = 5'd15,
    PH_DONE  = 5'd16,
    PH_ERR   = 5'd17
  } phase_t;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_SHORT    = 4'd1,
    ERR_RIFF     = 4'd2,
    ERR_WAVE     = 4'd3,
    ERR_FMT      = 4'd4,
    ERR_FMT_LEN  = 4'd5,
    ERR_CHANNELS = 4'd6,
    ERR_RATE     = 4'd7,
    ERR_BITS     = 4'd8,
    ERR_TAG      = 4'd9,
    ERR_NO_DATA  = 4'd10
  } err_t;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_PCM  = 2'd1,
    FMT_MP3  = 2'd2
  } stream_fmt_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } whp_in_t;

  typedef struct packed {
    logic [1:0]  stream_format;
    logic [3:0]  error_code;
    logic [1:0]  channel_count;
    logic [15:0] sample_rate;
    logic [4:0]  sample_bits;
    logic [10:0] header_length;
    logic [31:0] data_length;
    logic        size_mismatch;
  } whp_out_t;

  // Classification of one byte as it leaves the front end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       active;
  } whp_tag_t;

endpackage

// ===== rtl/whp_front.sv =====
// Front end: counts buffer bytes and tags each word for the parser queue.
module whp_front #(
  parameter int unsigned MAX_BUFFER = 1024,
  localparam int unsigned PosW = $clog2(MAX_BUFFER + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  whp_pkg::whp_in_t  in_data,
  output logic              push,
  input  logic              q_ready,
  output whp_pkg::whp_tag_t tag,
  output logic [PosW-1:0]   pos
);
  import whp_pkg::*;

  logic [PosW-1:0] count;
  logic [PosW-1:0] count_next;
  logic            in_range;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;
  assign in_range = count < PosW'(MAX_BUFFER);

  always_comb begin
    tag.data_byte = in_data.data_byte;
    tag.last_byte = in_data.last_byte;
    tag.active    = in_range;
    pos           = in_range ? count + PosW'(1) : count;
    count_next    = in_data.last_byte ? '0 : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/whp_queue.sv =====
// Short register queue between the front end and the parser.
module whp_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             pop,
  output logic [Width-1:0] rd_data
);
  import whp_pkg::*;

  logic [Width-1:0] slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  fill;

  assign wr_ready = fill != CntW'(Depth);
  assign rd_valid = fill != '0;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CntW'(1);
        2'b01:   fill <= fill - CntW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/whp_back.sv =====
// Parser back end: field assembly, checks, chunk skipping and result register.
module whp_back #(
  parameter int unsigned MAX_BUFFER = 1024,
  localparam int unsigned PosW = $clog2(MAX_BUFFER + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              pop,
  input  whp_pkg::whp_tag_t tag,
  input  logic [PosW-1:0]   pos,
  output logic              out_valid,
  input  logic              out_ready,
  output whp_pkg::whp_out_t out_data
);
  import whp_pkg::*;

  phase_t          phase, phase_next;
  logic [31:0]     fshift, fshift_next;
  logic [1:0]      fidx, fidx_next;
  logic [31:0]     riff_len, riff_len_next;
  logic [31:0]     remaining, remaining_next;
  logic [31:0]     fmt_len, fmt_len_next;
  logic [1:0]      fmt, fmt_next;
  logic [1:0]      chans, chans_next;
  logic [15:0]     rate, rate_next;
  logic [4:0]      bits, bits_next;
  logic [31:0]     dsize, dsize_next;
  err_t            err, err_next;
  logic [PosW-1:0] hdr, hdr_next;

  logic [31:0] sh;
  logic [31:0] v;
  logic [15:0] h;
  logic [31:0] skip_len;
  logic        len2;
  logic        complete;
  err_t        res_err;
  whp_out_t    res;

  // A last byte needs the result register free; other bytes always go.
  assign pop = q_valid && (!tag.last_byte || !out_valid || out_ready);

  always_comb begin
    phase_next     = phase;
    fshift_next    = fshift;
    fidx_next      = fidx;
    riff_len_next  = riff_len;
    remaining_next = remaining;
    fmt_len_next   = fmt_len;
    fmt_next       = fmt;
    chans_next     = chans;
    rate_next      = rate;
    bits_next      = bits;
    dsize_next     = dsize;
    err_next       = err;
    hdr_next       = hdr;
    sh             = {tag.data_byte, fshift[31:8]};
    h              = sh[31:16];
    len2           = (phase == PH_FTAG) || (phase == PH_CHAN) ||
                     (phase == PH_ALIGN) || (phase == PH_BITS);
    v              = len2 ? {sh[31:16], sh[31:16]} : sh;
    complete       = len2 ? (fidx == 2'd1) : (fidx == 2'd3);
    skip_len       = fmt_len - 32'd2;

    if (tag.active && (phase != PH_DONE) && (phase != PH_ERR)) begin
      if ((phase == PH_MSKIP) || (phase == PH_CSKIP)) begin
        remaining_next = remaining - 32'd1;
        if (remaining_next == '0) begin
          phase_next = PH_CTAG;
        end
      end else begin
        fshift_next = sh;
        fidx_next   = complete ? 2'd0 : fidx + 2'd1;
        if (complete) begin
          case (phase)
            PH_RIFF: begin
              if (v == TagRiff) phase_next = PH_RSIZE;
              else begin err_next = ERR_RIFF; phase_next = PH_ERR; end
            end
            PH_RSIZE: begin
              riff_len_next = v;
              phase_next    = PH_WAVE;
            end
            PH_WAVE: begin
              if (v == TagWave) phase_next = PH_FMT;
              else begin err_next = ERR_WAVE; phase_next = PH_ERR; end
            end
            PH_FMT: begin
              if (v == TagFmt) phase_next = PH_FLEN;
              else begin err_next = ERR_FMT; phase_next = PH_ERR; end
            end
            PH_FLEN: begin
              fmt_len_next = v;
              phase_next   = PH_FTAG;
            end
            PH_FTAG: begin
              if (h == FmtTagPcm) begin
                if (fmt_len != 32'd16) begin
                  err_next   = ERR_FMT_LEN;
                  phase_next = PH_ERR;
                end else begin
                  fmt_next   = FMT_PCM;
                  phase_next = PH_CHAN;
                end
              end else if (h == FmtTagMp3) begin
                if (fmt_len < 32'd2) begin
                  err_next   = ERR_FMT_LEN;
                  phase_next = PH_ERR;
                end else begin
                  fmt_next   = FMT_MP3;
                  chans_next = 2'd1;
                  bits_next  = 5'd8;
                  if (skip_len == '0) begin
                    phase_next = PH_CTAG;
                  end else begin
                    phase_next     = PH_MSKIP;
                    remaining_next = skip_len;
                  end
                end
              end else begin
                err_next   = ERR_TAG;
                phase_next = PH_ERR;
              end
            end
            PH_CHAN: begin
              if ((h == 16'd1) || (h == 16'd2)) begin
                chans_next = h[1:0];
                phase_next = PH_RATE;
              end else begin
                err_next   = ERR_CHANNELS;
                phase_next = PH_ERR;
              end
            end
            PH_RATE: begin
              if ((v == 32'd8000) || (v == 32'd11025) || (v == 32'd22050) ||
                  (v == 32'd44100)) begin
                rate_next  = v[15:0];
                phase_next = PH_BRATE;
              end else begin
                err_next   = ERR_RATE;
                phase_next = PH_ERR;
              end
            end
            PH_BRATE: phase_next = PH_ALIGN;
            PH_ALIGN: phase_next = PH_BITS;
            PH_BITS: begin
              if ((h == 16'd8) || (h == 16'd16)) begin
                bits_next  = h[4:0];
                phase_next = PH_CTAG;
              end else begin
                err_next   = ERR_BITS;
                phase_next = PH_ERR;
              end
            end
            PH_CTAG: phase_next = (v == TagData) ? PH_DSIZE : PH_CSIZE;
            PH_CSIZE: begin
              if (v == '0) begin
                phase_next = PH_CTAG;
              end else begin
                phase_next     = PH_CSKIP;
                remaining_next = v;
              end
            end
            PH_DSIZE: begin
              dsize_next = v;
              hdr_next   = pos;
              phase_next = PH_DONE;
            end
            default: phase_next = phase;
          endcase
        end
      end
    end

    if (pos < PosW'(MinHeader)) res_err = ERR_SHORT;
    else if (err_next != ERR_NONE) res_err = err_next;
    else if (phase_next != PH_DONE) res_err = ERR_NO_DATA;
    else res_err = ERR_NONE;

    res            = '0;
    res.error_code = res_err;
    if (res_err == ERR_NONE) begin
      res.stream_format = fmt_next;
      res.channel_count = chans_next;
      res.sample_rate   = rate_next;
      res.sample_bits   = bits_next;
      res.header_length = 11'(32'(hdr_next));
      res.data_length   = dsize_next;
      res.size_mismatch = (dsize_next + 32'(hdr_next)) != (riff_len_next + 32'd8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && tag.last_byte)) begin
      phase     <= PH_RIFF;
      fshift    <= '0;
      fidx      <= '0;
      riff_len  <= '0;
      remaining <= '0;
      fmt_len   <= '0;
      fmt       <= FMT_NONE;
      chans     <= '0;
      rate      <= '0;
      bits      <= '0;
      dsize     <= '0;
      err       <= ERR_NONE;
      hdr       <= '0;
    end else if (pop) begin
      phase     <= phase_next;
      fshift    <= fshift_next;
      fidx      <= fidx_next;
      riff_len  <= riff_len_next;
      remaining <= remaining_next;
      fmt_len   <= fmt_len_next;
      fmt       <= fmt_next;
      chans     <= chans_next;
      rate      <= rate_next;
      bits      <= bits_next;
      dsize     <= dsize_next;
      err       <= err_next;
      hdr       <= hdr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && tag.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tag.last_byte) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/wav_header_parser_top.sv =====
// Top level of the RIFF/WAVE header parser: front end, queue and parser.
//
//   Channel | Signals                       | Word
//   --------+-------------------------------+----------------------------------
//   in      | in_valid, in_ready, in_data   | one header byte plus last mark
//   out     | out_valid, out_ready, out_data| one parse result per buffer
//
// The block takes one byte per cycle. Each byte is parsed in the cycle it
// leaves the four-entry queue; a buffer's result is registered and appears in
// the cycle after its last byte is parsed. The parser state resets to the
// start of a new buffer on that last byte, so consecutive buffers follow with
// no gap. Reset is synchronous and active high. A result waiting in the
// output register holds back the next last byte at the head of the queue; the
// words behind it fill the queue, and input stalls once it holds four words.
module wav_header_parser_top #(
  parameter int unsigned MAX_BUFFER = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  whp_pkg::whp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output whp_pkg::whp_out_t out_data
);
  import whp_pkg::*;

  // Byte positions run up to MAX_BUFFER, so the counter holds that value.
  localparam int unsigned PosW   = $clog2(MAX_BUFFER + 1);
  localparam int unsigned EntryW = $bits(whp_tag_t) + PosW;

  logic              push;
  logic              q_ready;
  whp_tag_t          front_tag;
  logic [PosW-1:0]   front_pos;
  logic              q_valid;
  logic              pop;
  logic [EntryW-1:0] q_entry;
  whp_tag_t          back_tag;
  logic [PosW-1:0]   back_pos;

  // The front end counts bytes and marks those past the buffer limit as
  // inactive, so the parser ignores them but still sees the last mark.
  whp_front #(
    .MAX_BUFFER(MAX_BUFFER)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .push    (push),
    .q_ready (q_ready),
    .tag     (front_tag),
    .pos     (front_pos)
  );

  // The queue decouples byte acceptance from the parser and its result stall.
  whp_queue #(
    .Width(EntryW),
    .Depth(4)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_ready(q_ready),
    .wr_data ({front_tag, front_pos}),
    .rd_valid(q_valid),
    .pop     (pop),
    .rd_data (q_entry)
  );

  assign back_tag = q_entry[EntryW-1:PosW];
  assign back_pos = q_entry[PosW-1:0];

  // The parser assembles little-endian fields, runs the checks and skips
  // chunks, then registers one result per buffer.
  whp_back #(
    .MAX_BUFFER(MAX_BUFFER)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .pop      (pop),
    .tag      (back_tag),
    .pos      (back_pos),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
